// ===== rtl/core/bnc_pkg.sv =====
package bnc_pkg;

  // Stack geometry
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);

  // Bracket characters
  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;  // (
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;  // [
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;  // {
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;  // <
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;  // )
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;  // }
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;  // >

  // Bracket type held in each stack cell
  typedef enum logic [1:0] {
    BR_ROUND  = 2'd0,
    BR_SQUARE = 2'd1,
    BR_CURLY  = 2'd2,
    BR_ANGLE  = 2'd3
  } bnc_bracket_e;

  // Report kind
  typedef enum logic [1:0] {
    KIND_BALANCED = 2'd0,
    KIND_CORRUPT  = 2'd1,
    KIND_CLOSE    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } bnc_kind_e;

  // Character decode result
  typedef struct packed {
    logic         hit;
    bnc_bracket_e br;
  } bnc_decode_t;

  // Shift command to the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } bnc_shift_t;

  function automatic bnc_decode_t decode_opener(input logic [7:0] ch);
    bnc_decode_t d;
    d.hit = 1'b1;
    d.br  = BR_ROUND;
    unique case (ch)
      CH_OPEN_ROUND:  d.br = BR_ROUND;
      CH_OPEN_SQUARE: d.br = BR_SQUARE;
      CH_OPEN_CURLY:  d.br = BR_CURLY;
      CH_OPEN_ANGLE:  d.br = BR_ANGLE;
      default:        d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic bnc_decode_t decode_closer(input logic [7:0] ch);
    bnc_decode_t d;
    d.hit = 1'b1;
    d.br  = BR_ROUND;
    unique case (ch)
      CH_CLOSE_ROUND:  d.br = BR_ROUND;
      CH_CLOSE_SQUARE: d.br = BR_SQUARE;
      CH_CLOSE_CURLY:  d.br = BR_CURLY;
      CH_CLOSE_ANGLE:  d.br = BR_ANGLE;
      default:         d.hit = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] closer_char(input bnc_bracket_e br);
    logic [7:0] c;
    unique case (br)
      BR_ROUND:  c = CH_CLOSE_ROUND;
      BR_SQUARE: c = CH_CLOSE_SQUARE;
      BR_CURLY:  c = CH_CLOSE_CURLY;
      BR_ANGLE:  c = CH_CLOSE_ANGLE;
      default:   c = CH_CLOSE_ROUND;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/bracket_nesting_checker_core.sv =====
// Bracket nesting checker.
// Input channel: char_code_i / line_end_i under in_valid_i, in_stall_o. A
// transaction moves when valid is high and stall is low. One character is
// taken per cycle while scanning, a line end only if the output is free.
// Output channel: kind_o / char_code_out_o / last_o under out_valid_o,
// out_stall_i, held from a single output register.
// A line-ending character that ends in balanced, corrupted or overflow
// gives one report, valid the cycle after the transaction. If brackets
// remain open, the state moves to drain and the completing closers follow
// from the output register, one per cycle while it is free, top of stack
// first; the input stalls in drain as the cells shift up one entry each.
// The stack is a row of STACK_DEPTH cells that shift together: a push
// moves every entry down one cell, a pop moves every entry up one cell.
// A stall on the output holds the current result and stops the drain; a
// line-ending character is then refused, others still go in while scanning.
// Reset clears level, marks, state and the output valid; stack cell
// contents are not cleared and need no clearing pass.
module bracket_nesting_checker_core
  import bnc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] char_code_out_o,
  output logic       last_o
);

  typedef enum logic {
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e             state_q, state_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               corrupt_q, corrupt_d;
  logic               ovf_q, ovf_d;
  logic [7:0]         bad_q, bad_d;
  logic               out_valid_q, out_valid_d;
  bnc_kind_e          kind_q, kind_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               last_q, last_d;

  bnc_shift_t   shift;
  bnc_bracket_e cell_br [STACK_DEPTH];
  bnc_decode_t  op_dec, cl_dec;
  logic         out_free, accept, active;
  logic         push_ok, pop_ok, ovf_set, corrupt_set;
  logic         ovf_n, corrupt_n;
  logic [7:0]   bad_n;
  logic [LEVEL_W-1:0] level_n;

  // Output register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_DRAIN) || (line_end_i && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Character classification and stack update
  always_comb begin
    op_dec      = decode_opener(char_code_i);
    cl_dec      = decode_closer(char_code_i);
    active      = accept && !corrupt_q && !ovf_q;
    ovf_set     = active && op_dec.hit && (level_q == LEVEL_W'(STACK_DEPTH));
    push_ok     = active && op_dec.hit && (level_q != LEVEL_W'(STACK_DEPTH));
    pop_ok      = active && cl_dec.hit && (level_q != '0) && (cell_br[0] == cl_dec.br);
    corrupt_set = active && cl_dec.hit && !pop_ok;
    ovf_n       = ovf_q || ovf_set;
    corrupt_n   = corrupt_q || corrupt_set;
    bad_n       = corrupt_set ? char_code_i : bad_q;
    level_n     = level_q;
    if (push_ok) begin
      level_n = level_q + LEVEL_W'(1);
    end else if (pop_ok) begin
      level_n = level_q - LEVEL_W'(1);
    end
  end

  // Control and report sequencing
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    corrupt_d   = corrupt_q;
    ovf_d       = ovf_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    out_char_d  = out_char_q;
    last_d      = last_q;
    shift.push  = push_ok;
    shift.pop   = pop_ok;

    unique case (state_q)
      ST_SCAN: begin
        if (accept) begin
          level_d   = level_n;
          corrupt_d = corrupt_n;
          ovf_d     = ovf_n;
          bad_d     = bad_n;
          if (line_end_i) begin
            if (ovf_n || corrupt_n || (level_n == '0)) begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              if (ovf_n) begin
                kind_d     = KIND_OVERFLOW;
                out_char_d = '0;
              end else if (corrupt_n) begin
                kind_d     = KIND_CORRUPT;
                out_char_d = bad_n;
              end else begin
                kind_d     = KIND_BALANCED;
                out_char_d = '0;
              end
              level_d   = '0;
              corrupt_d = 1'b0;
              ovf_d     = 1'b0;
              bad_d     = '0;
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        // One completing closer per cycle from the top cell while output is free
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_CLOSE;
          out_char_d  = closer_char(cell_br[0]);
          last_d      = (level_q == LEVEL_W'(1));
          shift.pop   = 1'b1;
          level_d     = level_q - LEVEL_W'(1);
          if (level_q == LEVEL_W'(1)) begin
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SCAN;
      level_q     <= '0;
      corrupt_q   <= 1'b0;
      ovf_q       <= 1'b0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_BALANCED;
      out_char_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      corrupt_q   <= corrupt_d;
      ovf_q       <= ovf_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      out_char_q  <= out_char_d;
      last_q      <= last_d;
    end
  end

  // Cell chain, cell 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bnc_bracket_e upper, lower;
    if (i == 0) begin : g_top
      assign upper = op_dec.br;
    end else begin : g_mid
      assign upper = cell_br[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign lower = cell_br[i];
    end else begin : g_inner
      assign lower = cell_br[i+1];
    end
    bnc_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .upper_i (upper),
      .lower_i (lower),
      .br_o    (cell_br[i])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign char_code_out_o = out_char_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/core/bnc_cell.sv =====
module bnc_cell
  import bnc_pkg::*;
(
  input  logic         clk_i,
  input  bnc_shift_t   shift_i,
  input  bnc_bracket_e upper_i,
  input  bnc_bracket_e lower_i,
  output bnc_bracket_e br_o
);

  bnc_bracket_e br_q, br_d;

  // Push takes the entry above, pop takes the entry below
  always_comb begin
    br_d = br_q;
    if (shift_i.push) begin
      br_d = upper_i;
    end else if (shift_i.pop) begin
      br_d = lower_i;
    end
  end

  // Payload only, undefined until written
  always_ff @(posedge clk_i) begin
    br_q <= br_d;
  end

  assign br_o = br_q;

endmodule
